// ===== sv/sisp_pkg.sv =====
// Shared types, constants and helpers for the sorted integer set pair.
package sisp_pkg;

    localparam int CAPACITY = 64;
    localparam int ELEM_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ACT_W    = 2;
    localparam int RANK_W   = 6;
    localparam int STAT_W   = 3;
    localparam int LEN_W    = 7;
    localparam int REL_W    = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_READ   = 2'd2
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_DELETED   = 3'd3,
        ST_ABSENT    = 3'd4,
        ST_READ_OK   = 3'd5,
        ST_PAST_END  = 3'd6
    } t_status;

    typedef enum logic [REL_W-1:0] {
        REL_DIFFER   = 2'd0,
        REL_EQUAL    = 2'd1,
        REL_A_HAS_B  = 2'd2,
        REL_B_HAS_A  = 2'd3
    } t_relation;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture an input beat
        logic compare;  // register the per-cell compare results
        logic commit;   // update the sets and load the result register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free; // result register can take a beat this cycle
    } t_stat;

    function automatic t_relation relation_of(input logic [CNT_W-1:0] ca,
                                              input logic [CNT_W-1:0] cb,
                                              input logic [CNT_W-1:0] cc);
        logic only_a;
        logic only_b;
        only_a = (ca != cc);
        only_b = (cb != cc);
        if (only_a && only_b) begin
            return REL_DIFFER;
        end else if (!only_a && !only_b) begin
            return REL_EQUAL;
        end else if (!only_b) begin
            return REL_A_HAS_B;
        end else begin
            return REL_B_HAS_A;
        end
    endfunction

endpackage

// ===== sv/sisp_ctrl.sv =====
// Controller state machine: sequences load, compare and commit per item.
module sisp_ctrl
    import sisp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (i_stat.out_free) n_state = i_valid ? S_CMP : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = i_rst_n;
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
            end
            S_UPD: begin
                o_cmd.commit = i_stat.out_free;
                o_ready      = i_stat.out_free;
            end
            default: o_ready = 1'b0;
        endcase
        o_cmd.load = o_ready && i_valid;
    end

endmodule

// ===== sv/sisp_dp.sv =====
// Datapath: two rows of sorted compare-and-shift cells, counts, result register.
module sisp_dp
    import sisp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [ACT_W-1:0]  i_action,
    input  logic              i_which_set,
    input  logic [ELEM_W-1:0] i_element,
    input  logic [RANK_W-1:0] i_rank,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [ELEM_W-1:0] o_read_value,
    output logic [LEN_W-1:0]  o_length_a,
    output logic [LEN_W-1:0]  o_length_b,
    output logic [REL_W-1:0]  o_relation
);

    logic [ELEM_W-1:0] r_store_a [CAPACITY];
    logic [ELEM_W-1:0] r_store_b [CAPACITY];
    logic [CNT_W-1:0]  r_cnt_a, r_cnt_b, r_common;
    logic [ACT_W-1:0]  r_action;
    logic              r_which;
    logic [ELEM_W-1:0] r_elem;
    logic [RANK_W-1:0] r_rank;
    logic [CAPACITY-1:0] r_lt;
    logic              r_found, r_other;

    logic              r_out_valid;
    t_status           r_out_status;
    logic [ELEM_W-1:0] r_out_value;
    logic [CNT_W-1:0]  r_out_len_a, r_out_len_b;
    t_relation         r_out_rel;

    logic [ELEM_W-1:0] cur   [CAPACITY];
    logic [ELEM_W-1:0] oth   [CAPACITY];
    logic [ELEM_W-1:0] ins_v [CAPACITY];
    logic [ELEM_W-1:0] del_v [CAPACITY];
    logic [CAPACITY-1:0] lt_sel, eq_sel, eq_oth;
    logic [CNT_W-1:0]  cnt_sel, cnt_oth;

    assign cnt_sel = r_which ? r_cnt_b : r_cnt_a;
    assign cnt_oth = r_which ? r_cnt_a : r_cnt_b;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam logic [CNT_W-1:0] POS = CNT_W'(g);
        assign cur[g]    = r_which ? r_store_b[g] : r_store_a[g];
        assign oth[g]    = r_which ? r_store_a[g] : r_store_b[g];
        assign lt_sel[g] = (POS < cnt_sel) && (cur[g] < r_elem);
        assign eq_sel[g] = (POS < cnt_sel) && (cur[g] == r_elem);
        assign eq_oth[g] = (POS < cnt_oth) && (oth[g] == r_elem);
        if (g == 0) begin : g_first
            assign ins_v[g] = r_lt[g] ? cur[g] : r_elem;
        end else begin : g_rest
            assign ins_v[g] = r_lt[g] ? cur[g] : (r_lt[g-1] ? r_elem : cur[g-1]);
        end
        if (g == CAPACITY - 1) begin : g_last
            assign del_v[g] = cur[g];
        end else begin : g_inner
            assign del_v[g] = r_lt[g] ? cur[g] : cur[g+1];
        end
    end

    // Decide the outcome of the held item from the registered compares
    logic              do_ins, do_del, rd_ok;
    t_status           n_status;
    logic [ELEM_W-1:0] n_value;
    logic [CNT_W-1:0]  n_cnt_a, n_cnt_b, n_common;

    always_comb begin
        do_ins   = 1'b0;
        do_del   = 1'b0;
        rd_ok    = (CNT_W'(r_rank) < cnt_sel);
        n_value  = '0;
        n_status = ST_PAST_END;
        case (r_action)
            ACT_INSERT: begin
                if (r_found) begin
                    n_status = ST_DUPLICATE;
                end else if (cnt_sel >= CNT_W'(CAPACITY)) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_INSERTED;
                    do_ins   = 1'b1;
                end
            end
            ACT_DELETE: begin
                n_status = r_found ? ST_DELETED : ST_ABSENT;
                do_del   = r_found;
            end
            default: begin
                if (rd_ok) begin
                    n_status = ST_READ_OK;
                    n_value  = cur[IDX_W'(r_rank)];
                end
            end
        endcase
        n_cnt_a  = r_cnt_a;
        n_cnt_b  = r_cnt_b;
        n_common = r_common;
        if (do_ins) begin
            if (r_which) n_cnt_b = r_cnt_b + 1'b1;
            else         n_cnt_a = r_cnt_a + 1'b1;
            if (r_other) n_common = r_common + 1'b1;
        end
        if (do_del) begin
            if (r_which) n_cnt_b = r_cnt_b - 1'b1;
            else         n_cnt_a = r_cnt_a - 1'b1;
            if (r_other && r_common != '0) n_common = r_common - 1'b1;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_which  <= i_which_set;
            r_elem   <= i_element;
            r_rank   <= i_rank;
        end
        if (i_cmd.compare) begin
            r_lt    <= lt_sel;
            r_found <= |eq_sel;
            r_other <= |eq_oth;
        end
        if (i_cmd.commit) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (do_ins || do_del) begin
                    if (r_which) r_store_b[i] <= do_ins ? ins_v[i] : del_v[i];
                    else         r_store_a[i] <= do_ins ? ins_v[i] : del_v[i];
                end
            end
            r_out_status <= n_status;
            r_out_value  <= n_value;
            r_out_len_a  <= n_cnt_a;
            r_out_len_b  <= n_cnt_b;
            r_out_rel    <= relation_of(n_cnt_a, n_cnt_b, n_common);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_common    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_cnt_a  <= n_cnt_a;
                r_cnt_b  <= n_cnt_b;
                r_common <= n_common;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_read_value = r_out_value;
    assign o_length_a   = LEN_W'(r_out_len_a);
    assign o_length_b   = LEN_W'(r_out_len_b);
    assign o_relation   = r_out_rel;

endmodule

// ===== sv/sorted_integer_set_pair_top.sv =====
// Top level of the sorted integer set pair: controller plus cell datapath.
// The result becomes valid at the commit edge, which follows the compare edge after the accepting edge.
// The compare and commit passes over the cell rows are separate controller states,
//   and the commit waits until the result register is free; the controller overlaps
//   the next accept with the commit, so a new item is taken before the last is done.
// The result register frees the input side: a new beat is taken while a result waits.
// Reset (i_rst_n low, synchronous) empties both sets and drops any pending result.
module sorted_integer_set_pair_top
    import sisp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [ACT_W-1:0]  i_action,
    input  logic              i_which_set,
    input  logic [ELEM_W-1:0] i_element,
    input  logic [RANK_W-1:0] i_rank,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [ELEM_W-1:0] o_read_value,
    output logic [LEN_W-1:0]  o_length_a,
    output logic [LEN_W-1:0]  o_length_b,
    output logic [REL_W-1:0]  o_relation
);

    // Command and status between controller and datapath
    t_cmd  cmd;
    t_stat stat;

    // Sequence each beat: capture, compare, commit
    sisp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Hold both sets, the counts and the result register
    sisp_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_action     (i_action),
        .i_which_set  (i_which_set),
        .i_element    (i_element),
        .i_rank       (i_rank),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_length_a   (o_length_a),
        .o_length_b   (o_length_b),
        .o_relation   (o_relation)
    );

endmodule

// ===== sv/sisp_checker.sv =====
// Port-level checks for the sorted integer set pair, bound to the top level.
module sisp_checker
    import sisp_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_ready,
    input logic [STAT_W-1:0] o_status,
    input logic [ELEM_W-1:0] o_read_value,
    input logic [LEN_W-1:0]  o_length_a,
    input logic [LEN_W-1:0]  o_length_b,
    input logic [REL_W-1:0]  o_relation
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_read_value))
        else $error("result beat changed while stalled");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_READ_OK |-> o_read_value == '0)
        else $error("read value nonzero without a successful read");

    a_equal_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_relation == REL_EQUAL |-> o_length_a == o_length_b)
        else $error("equal sets with different lengths");

    a_contain_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_relation == REL_A_HAS_B |-> o_length_a > o_length_b)
        else $error("A contains B but is not longer");

endmodule

bind sorted_integer_set_pair_top sisp_checker u_sisp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_status     (o_status),
    .o_read_value (o_read_value),
    .o_length_a   (o_length_a),
    .o_length_b   (o_length_b),
    .o_relation   (o_relation)
);

// ===== tb/sv/sorted_integer_set_pair_checker.sv =====
// Checker for the sorted integer set pair: mirrors both sets and scores each result beat.
module sorted_integer_set_pair_checker
    import sisp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_ready_in,
    input  logic [ACT_W-1:0]  i_action,
    input  logic              i_which_set,
    input  logic [ELEM_W-1:0] i_element,
    input  logic [RANK_W-1:0] i_rank,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [STAT_W-1:0] i_status,
    input  logic [ELEM_W-1:0] i_read_value,
    input  logic [LEN_W-1:0]  i_length_a,
    input  logic [LEN_W-1:0]  i_length_b,
    input  logic [REL_W-1:0]  i_relation,
    output int                o_errors,
    output int                o_pending,
    output int                o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ELEM_W-1:0] value;
        logic [LEN_W-1:0]  len_a;
        logic [LEN_W-1:0]  len_b;
        logic [REL_W-1:0]  rel;
    } t_set_result;

    logic [ELEM_W-1:0] members [2][$];  // mirror of each set, ascending
    int                shared;          // elements held by both sets
    t_set_result       expected_results [$];

    function automatic int find_pos(int s, logic [ELEM_W-1:0] x);
        int i;
        i = 0;
        while (i < members[s].size() && members[s][i] < x) i++;
        return i;
    endfunction

    function automatic bit is_member(int s, logic [ELEM_W-1:0] x);
        int p;
        p = find_pos(s, x);
        return p < members[s].size() && members[s][p] == x;
    endfunction

    function automatic t_set_result apply_set_op(logic [ACT_W-1:0] act, int s,
                                                logic [ELEM_W-1:0] x,
                                                logic [RANK_W-1:0] rk);
        t_set_result r;
        int p, oa, ob;
        r = '0;
        p = find_pos(s, x);
        if (act == ACT_INSERT) begin
            if (p < members[s].size() && members[s][p] == x) begin
                r.status = ST_DUPLICATE;
            end else if (members[s].size() >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                members[s].insert(p, x);
                if (is_member(1 - s, x)) shared++;
                r.status = ST_INSERTED;
            end
        end else if (act == ACT_DELETE) begin
            if (p < members[s].size() && members[s][p] == x) begin
                members[s].delete(p);
                if (is_member(1 - s, x) && shared > 0) shared--;
                r.status = ST_DELETED;
            end else begin
                r.status = ST_ABSENT;
            end
        end else if (rk < members[s].size()) begin
            // unused action code falls through to a read
            r.value  = members[s][rk];
            r.status = ST_READ_OK;
        end else begin
            r.status = ST_PAST_END;
        end
        r.len_a = LEN_W'(members[0].size());
        r.len_b = LEN_W'(members[1].size());
        oa = members[0].size() - shared;
        ob = members[1].size() - shared;
        if (oa != 0 && ob != 0) r.rel = REL_DIFFER;
        else if (oa == 0 && ob == 0) r.rel = REL_EQUAL;
        else if (ob == 0) r.rel = REL_A_HAS_B;
        else r.rel = REL_B_HAS_A;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_set_result got, want;
        if (!i_rst_n) begin
            members[0].delete();
            members[1].delete();
            shared = 0;
            expected_results.delete();
            o_errors  <= 0;
            o_results <= 0;
        end else begin
            if (i_valid && i_ready_in)
                expected_results.push_back(apply_set_op(i_action, int'(i_which_set),
                                                        i_element, i_rank));
            if (i_out_valid && i_out_ready) begin
                got = {i_status, i_read_value, i_length_a, i_length_b, i_relation};
                o_results <= o_results + 1;
                if (expected_results.size() == 0) begin
                    if (o_errors < 10)
                        $display("%0t: unexpected result beat %p", $realtime, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got != want) begin
                        if (o_errors < 10)
                            $display("%0t: mismatch exp %p got %p", $realtime, want, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= expected_results.size();
    end
endmodule

// ===== tb/sv/tb_sorted_integer_set_pair_top.sv =====
// Testbench top for the sorted integer set pair: stimulus, back-pressure and verdict.
module tb_sorted_integer_set_pair_top;
    import sisp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;  // spare code, reads like a read

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [ACT_W-1:0]  i_action = '0;
    logic              i_which_set = 1'b0;
    logic [ELEM_W-1:0] i_element = '0;
    logic [RANK_W-1:0] i_rank = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [STAT_W-1:0] o_status;
    logic [ELEM_W-1:0] o_read_value;
    logic [LEN_W-1:0]  o_length_a;
    logic [LEN_W-1:0]  o_length_b;
    logic [REL_W-1:0]  o_relation;

    int  errors, pending, results;
    int  idle_pct = 31;     // idle chance per cycle on each side, in percent
    bit  rx_hold  = 1'b0;   // receiver hold-off request
    int  stall_cycles;
    int  beats_in;
    logic [ELEM_W-1:0] pool [16];  // small value pool so sets overlap
    logic [ELEM_W-1:0] fill_vals [CAPACITY];  // values used to fill set A

    always #5 i_clk = ~i_clk;

    sorted_integer_set_pair_top u_dut (.*);

    sorted_integer_set_pair_checker u_chk (
        .i_clk, .i_rst_n, .i_valid, .i_ready_in(o_ready), .i_action, .i_which_set,
        .i_element, .i_rank, .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_status(o_status), .i_read_value(o_read_value), .i_length_a(o_length_a),
        .i_length_b(o_length_b), .i_relation(o_relation),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // Receiver: random stalls unless a hold-off is requested.
    always @(posedge i_clk) begin
        i_ready <= i_rst_n && !rx_hold && ($urandom_range(99) >= idle_pct);
    end

    // Watchdog: end the run after a long stretch with no beat on either side.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles > 20000) begin
                $display("watchdog expired");
                $display("** sorted_integer_set_pair_top: FAILED **");
                $finish;
            end
        end
    end

    // Offer one beat after a random gap; hold it until accepted.
    task automatic send_op(logic [ACT_W-1:0] act, logic s, logic [ELEM_W-1:0] x,
                           logic [RANK_W-1:0] rk);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_action    <= act;
        i_which_set <= s;
        i_element   <= x;
        i_rank      <= rk;
        do @(posedge i_clk); while (!o_ready);
        beats_in++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_op(bit wide);
        logic [ELEM_W-1:0] x;
        int r;
        r = $urandom_range(99);
        x = wide ? $urandom() : pool[$urandom_range(15)];
        send_op(r < 45 ? ACT_INSERT : r < 75 ? ACT_DELETE : r < 97 ? ACT_READ : ACT_UNUSED,
                1'($urandom_range(1)), x, RANK_W'($urandom_range(63)));
    endtask

    initial begin
        foreach (pool[k]) pool[k] = $urandom();
        pool[0] = '0;
        pool[1] = '1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty sets are equal, reads past end, absent delete,
        // extremes, duplicate, unused action code reads, containment both ways.
        send_op(ACT_READ, 1'b0, '0, 6'd0);
        send_op(ACT_DELETE, 1'b1, 32'h5, 6'd0);
        send_op(ACT_INSERT, 1'b0, '1, 6'd0);
        send_op(ACT_INSERT, 1'b0, '0, 6'd0);
        send_op(ACT_INSERT, 1'b0, '0, 6'd0);
        send_op(ACT_INSERT, 1'b1, '1, 6'd0);
        send_op(ACT_INSERT, 1'b1, 32'h8000_0000, 6'd0);
        send_op(ACT_UNUSED, 1'b0, '0, 6'd1);
        send_op(ACT_READ, 1'b1, '0, 6'd63);
        send_op(ACT_INSERT, 1'b1, '0, 6'd0);
        send_op(ACT_DELETE, 1'b1, 32'h8000_0000, 6'd0);
        send_op(ACT_DELETE, 1'b0, '1, 6'd0);
        send_op(ACT_DELETE, 1'b0, '0, 6'd0);
        send_op(ACT_DELETE, 1'b1, '0, 6'd0);
        send_op(ACT_DELETE, 1'b1, '1, 6'd0);

        // Fill set A to capacity, then check full, duplicate-when-full and top rank.
        for (int k = 0; k < CAPACITY; k++) begin
            fill_vals[k] = $urandom();
            send_op(ACT_INSERT, 1'b0, fill_vals[k], 6'd0);
        end
        send_op(ACT_INSERT, 1'b0, 32'h1234_5678, 6'd0);
        send_op(ACT_INSERT, 1'b0, fill_vals[0], 6'd0);
        send_op(ACT_READ, 1'b0, '0, 6'd63);
        for (int k = 0; k < 20; k++)
            send_op(ACT_READ, 1'b0, '0, RANK_W'($urandom_range(63)));
        drain_results();  // sender pauses until every result is back

        // Long receiver hold-off while the sender keeps offering beats.
        rx_hold = 1'b1;
        fork
            begin repeat (200) @(posedge i_clk); rx_hold = 1'b0; end
            for (int k = 0; k < 10; k++) random_op(1'b0);
        join

        // Main random part: small pool for overlap, some wide values;
        // partway through, empty A of its fill values.
        for (int k = 0; k < 700; k++) begin
            if (k == 250) idle_pct = 0;    // stretch with no idling
            if (k == 400) idle_pct = 31;
            if (k == 500) begin
                // clear A so pool-based traffic sees small sets
                drain_results();
                for (int j = 0; j < CAPACITY; j++)
                    send_op(ACT_DELETE, 1'b0, fill_vals[j], 6'd0);
            end
            random_op($urandom_range(9) == 0);
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d beats and scored %0d results: inserts, deletes, reads,",
                 beats_in, results);
        $display("a full set, overlapping sets and both stall directions.");
        if (errors == 0 && pending == 0) begin
            $display("** sorted_integer_set_pair_top: PASSED **");
        end else begin
            $display("** sorted_integer_set_pair_top: FAILED **");
        end
        $finish;
    end
endmodule
